FILE: rtl/fvrt_pkg.sv
// Shared constants and types for the framed value receiver.
package fvrt_pkg;

  localparam logic [7:0]         START_CODE    = 8'h55;
  localparam logic [7:0]         STOP_CODE     = 8'hAA;
  localparam logic signed [15:0] THRESH_RESET  = -16'sd140;

  // One received byte held in the input register
  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
  } fvrt_beat_t;

endpackage

FILE: rtl/framed_value_receiver_threshold.sv
// Top level of the framed value receiver with threshold indicator.
//
// Input channel: one received byte per beat on in_rx_byte (in_valid/in_stall).
// The parser looks for start 0x55, a signed 16-bit value high byte first,
// an 8-bit additive checksum of the two value bytes, and stop 0xAA.
// Result channel: exactly one result beat per input beat, in order, carrying
// frame_valid, checksum_error, the last accepted value and the held
// indicator (value greater than threshold, signed).
// Configuration: cfg_we writes cfg_wdata to the signed threshold; write it
// only while no byte is in flight.
// The input register loads at the accepting edge and feeds the result register,
// where out_valid rises. Throughput is one byte per cycle while the receiver does
// not stall; the single parser step between the two registers sets that rate.
// Reset (rst_n low, synchronous) clears the parser to idle, the value and
// the indicator to zero, and sets the threshold to -140.
// When the receiver stalls, the result beat holds; an empty input register
// still takes one more byte, after which in_stall rises until the result drains.
module framed_value_receiver_threshold (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_valid,
  output logic               out_checksum_error,
  output logic signed [15:0] out_value,
  output logic               out_indicator_on,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata
);
  import fvrt_pkg::*;

  fvrt_beat_t beat;
  logic       ready;

  // Input register
  fvrt_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .down_ready (ready),
    .beat       (beat)
  );

  // Parser and result register
  fvrt_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .beat               (beat),
    .ready              (ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_valid    (out_frame_valid),
    .out_checksum_error (out_checksum_error),
    .out_value          (out_value),
    .out_indicator_on   (out_indicator_on)
  );

endmodule

FILE: rtl/fvrt_in_stage.sv
// Input register stage: captures one received byte per beat.
module fvrt_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              down_ready,
  output fvrt_pkg::fvrt_beat_t beat
);
  import fvrt_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       take;

  // Full and the parser cannot take it: hold off the sender
  assign in_stall = vld_r && !down_ready;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt  = vld_r;
    byte_nxt = byte_r;
    if (take) begin
      vld_nxt  = 1'b1;
      byte_nxt = in_rx_byte;
    end else if (down_ready) begin
      vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign beat.vld     = vld_r;
  assign beat.rx_byte = byte_r;

endmodule

FILE: rtl/fvrt_parser.sv
// Frame parser, threshold register and result register.
module fvrt_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic signed [15:0]   cfg_wdata,
  input  fvrt_pkg::fvrt_beat_t beat,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_frame_valid,
  output logic                 out_checksum_error,
  output logic signed [15:0]   out_value,
  output logic                 out_indicator_on
);
  import fvrt_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_HIGH  = 3'd2,
    PH_LOW   = 3'd3,
    PH_CSUM  = 3'd4
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [15:0]        partial_r, partial_nxt;
  logic signed [15:0] accepted_r, accepted_nxt;
  logic               ind_r, ind_nxt;
  logic signed [15:0] thresh_r;
  logic               ovld_r, ovld_nxt;
  logic               ok_r, ok_nxt;
  logic               err_r, err_nxt;
  logic               step;
  logic [7:0]         sum;
  logic [7:0]         b;

  // Result register free or being drained this cycle
  assign ready = !ovld_r || !out_stall;
  assign step  = beat.vld && ready;
  assign b     = beat.rx_byte;
  assign sum   = partial_r[15:8] + partial_r[7:0];

  // Parser step for one byte
  always_comb begin
    phase_nxt    = phase_r;
    partial_nxt  = partial_r;
    accepted_nxt = accepted_r;
    ind_nxt      = ind_r;
    ok_nxt       = ok_r;
    err_nxt      = err_r;
    ovld_nxt     = ready ? beat.vld : ovld_r;
    if (step) begin
      ok_nxt  = 1'b0;
      err_nxt = 1'b0;
      unique case (phase_r)
        PH_START: begin
          partial_nxt = {b, 8'h00};
          phase_nxt   = PH_HIGH;
        end
        PH_HIGH: begin
          partial_nxt = {partial_r[15:8], b};
          phase_nxt   = PH_LOW;
        end
        PH_LOW: begin
          if (sum == b) begin
            phase_nxt = PH_CSUM;
          end else begin
            err_nxt   = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_CSUM: begin
          if (b == STOP_CODE) begin
            accepted_nxt = partial_r;
            ok_nxt       = 1'b1;
            ind_nxt      = $signed(partial_r) > thresh_r;
          end
          phase_nxt = PH_IDLE;
        end
        default: begin
          // idle, and unused codes behave as idle
          partial_nxt = '0;
          phase_nxt   = (b == START_CODE) ? PH_START : PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      partial_r  <= '0;
      accepted_r <= '0;
      ind_r      <= 1'b0;
      thresh_r   <= THRESH_RESET;
      ovld_r     <= 1'b0;
      ok_r       <= 1'b0;
      err_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      partial_r  <= partial_nxt;
      accepted_r <= accepted_nxt;
      ind_r      <= ind_nxt;
      ovld_r     <= ovld_nxt;
      ok_r       <= ok_nxt;
      err_r      <= err_nxt;
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
    end
  end

  assign out_valid          = ovld_r;
  assign out_frame_valid    = ok_r;
  assign out_checksum_error = err_r;
  assign out_value          = accepted_r;
  assign out_indicator_on   = ind_r;

endmodule

FILE: bench/tb_framed_value_receiver_threshold.sv
// Self-checking testbench for the framed value receiver with threshold indicator.
`timescale 1ns / 100ps

module tb_framed_value_receiver_threshold;
  import fvrt_pkg::*;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_HIGH   = 3'd2,
    PH_LOW    = 3'd3,
    PH_SUM_OK = 3'd4
  } frame_phase_t;

  // Fields of one result beat
  typedef struct packed {
    logic               frame_valid;
    logic               checksum_error;
    logic signed [15:0] value;
    logic               indicator_on;
  } rx_result_t;

  localparam int PHASE_BYTES  = 60;
  localparam int DRAIN_CYCLES = 4;

  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               in_valid           = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte         = 8'h00;
  logic               out_valid;
  logic               out_stall          = 1'b0;
  logic               out_frame_valid;
  logic               out_checksum_error;
  logic signed [15:0] out_value;
  logic               out_indicator_on;
  logic               cfg_we             = 1'b0;
  logic signed [15:0] cfg_wdata          = 16'sd0;

  // Pending bytes for the sender, expected results for the checker
  logic [7:0]  pending_bytes [$];
  rx_result_t  expected_results [$];

  // Predictor state
  frame_phase_t       fp_phase     = PH_IDLE;
  logic [15:0]        fp_partial   = 16'h0000;
  logic signed [15:0] fp_value     = 16'sd0;
  logic               fp_indicator = 1'b0;
  logic signed [15:0] fp_threshold = THRESH_RESET;

  // Idling control and bookkeeping
  int unsigned gap_pct       = 0;
  int unsigned stall_pct     = 0;
  int unsigned gap_left      = 0;
  int unsigned stall_left    = 0;
  bit          rx_beat_taken = 1'b0;
  int          mismatch_count = 0;
  int          bytes_sent     = 0;
  int          good_frames    = 0;
  int          csum_errors    = 0;
  int          threshold_settings = 1;

  // Directed opening: idle noise, extreme values, checksum error on a start code,
  // bad stop on a start code, stray stop in idle
  logic [7:0] directed_seq [23] = '{
    8'h00, 8'hFF,
    8'h55, 8'h7F, 8'hFF, 8'h7E, 8'hAA,
    8'h55, 8'h80, 8'h00, 8'h80, 8'hAA,
    8'h55, 8'h12, 8'h34, 8'h55, 8'h12,
    8'h55, 8'h00, 8'h01, 8'h01, 8'h55,
    8'hAA
  };

  framed_value_receiver_threshold dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_valid    (out_frame_valid),
    .out_checksum_error (out_checksum_error),
    .out_value          (out_value),
    .out_indicator_on   (out_indicator_on),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  always #10 clk = ~clk;

  // One parser step: advance the predicted state by one byte, return the result
  function automatic rx_result_t parse_step(logic [7:0] rx);
    rx_result_t r;
    logic [7:0] sum;
    r = '0;
    case (fp_phase)
      PH_START: begin
        fp_partial = {rx, 8'h00};
        fp_phase   = PH_HIGH;
      end
      PH_HIGH: begin
        fp_partial = fp_partial | {8'h00, rx};
        fp_phase   = PH_LOW;
      end
      PH_LOW: begin
        sum = fp_partial[15:8] + fp_partial[7:0];
        if (sum == rx) begin
          fp_phase = PH_SUM_OK;
        end else begin
          r.checksum_error = 1'b1;
          fp_phase         = PH_IDLE;
        end
      end
      PH_SUM_OK: begin
        if (rx == STOP_CODE) begin
          fp_value      = fp_partial;
          fp_indicator  = (fp_value > fp_threshold);
          r.frame_valid = 1'b1;
        end
        fp_phase = PH_IDLE;
      end
      default: begin
        fp_partial = 16'h0000;
        fp_phase   = (rx == START_CODE) ? PH_START : PH_IDLE;
      end
    endcase
    r.value        = fp_value;
    r.indicator_on = fp_indicator;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sender: holds a beat until taken, otherwise idles in bursts or sends the next byte
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !rx_beat_taken) begin
      // stalled beat stays as is
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      gap_left = $urandom_range(10, 0);
    end else if (pending_bytes.size() != 0) begin
      in_rx_byte <= pending_bytes.pop_front();
      in_valid   <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(10, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on every input beat, check every result beat
  always @(posedge clk) begin
    rx_result_t exp_r;
    rx_beat_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        rx_beat_taken = 1'b1;
        bytes_sent++;
        expected_results.push_back(parse_step(in_rx_byte));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no byte pending");
        end else begin
          exp_r = expected_results.pop_front();
          if (out_frame_valid !== exp_r.frame_valid)
            report_mismatch($sformatf("frame_valid %b, want %b",
                                      out_frame_valid, exp_r.frame_valid));
          if (out_checksum_error !== exp_r.checksum_error)
            report_mismatch($sformatf("checksum_error %b, want %b",
                                      out_checksum_error, exp_r.checksum_error));
          if (out_value !== exp_r.value)
            report_mismatch($sformatf("value %0d, want %0d", out_value, exp_r.value));
          if (out_indicator_on !== exp_r.indicator_on)
            report_mismatch($sformatf("indicator_on %b, want %b",
                                      out_indicator_on, exp_r.indicator_on));
          if (exp_r.frame_valid) good_frames++;
          if (exp_r.checksum_error) csum_errors++;
        end
      end
    end
  end

  // Wait until the sender is empty and every result is back, then let the pipe settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic signed [15:0] thr);
    @(negedge clk);
    cfg_wdata <= thr;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we       <= 1'b0;
    fp_threshold = thr;
  endtask

  // Queue one frame; optionally spoil the checksum or the stop byte
  task automatic queue_frame(input logic [15:0] val, input bit bad_sum, input bit bad_stop);
    logic [7:0] sum;
    logic [7:0] stop;
    sum = val[15:8] + val[7:0];
    if (bad_sum) sum = sum ^ 8'($urandom_range(255, 1));
    stop = STOP_CODE;
    if (bad_stop) begin
      stop = 8'($urandom_range(255));
      if (stop == STOP_CODE) stop = START_CODE;
    end
    pending_bytes.push_back(START_CODE);
    pending_bytes.push_back(val[15:8]);
    pending_bytes.push_back(val[7:0]);
    pending_bytes.push_back(sum);
    pending_bytes.push_back(stop);
  endtask

  // Random phase: mostly frames, often near the threshold, some cut short, some noise
  task automatic queue_random_phase();
    int          count;
    int unsigned pick;
    int unsigned cut;
    int unsigned noise;
    logic [15:0] val;
    count = 0;
    while (count < PHASE_BYTES) begin
      pick = $urandom_range(99);
      case ($urandom_range(7))
        0:       val = fp_threshold;
        1:       val = fp_threshold + 16'sd1;
        2:       val = fp_threshold - 16'sd1;
        3:       val = 16'h7FFF;
        4:       val = 16'h8000;
        default: val = 16'($urandom());
      endcase
      if (pick < 75) begin
        queue_frame(val, $urandom_range(99) < 10, $urandom_range(99) < 10);
        count += 5;
      end else if (pick < 87) begin
        // frame cut short, then whatever follows lands in the middle
        cut = $urandom_range(3);
        pending_bytes.push_back(START_CODE);
        repeat (cut) pending_bytes.push_back(8'($urandom_range(255)));
        count += cut + 1;
      end else begin
        noise = $urandom_range(3, 1);
        repeat (noise) pending_bytes.push_back(8'($urandom_range(255)));
        count += noise;
      end
    end
  endtask

  // Run sequence
  initial begin
    logic signed [15:0] thr_list [8];
    thr_list = '{THRESH_RESET, 16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1,
                 16'($urandom()), 16'($urandom()), 16'($urandom())};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed bytes under the reset threshold
    gap_pct   = 20;
    stall_pct = 20;
    foreach (directed_seq[i]) pending_bytes.push_back(directed_seq[i]);
    wait_drained();

    // Random phases across threshold settings; one phase runs with no idling
    foreach (thr_list[i]) begin
      write_threshold(thr_list[i]);
      threshold_settings++;
      if (i == 3) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(40, 5);
        stall_pct = $urandom_range(40, 5);
      end
      queue_random_phase();
      wait_drained();
    end

    // Closing stretch: random threshold, no idling on either side
    write_threshold(16'($urandom()));
    threshold_settings++;
    gap_pct   = 0;
    stall_pct = 0;
    queue_random_phase();
    wait_drained();

    $display("Run covered %0d bytes under %0d threshold settings:", bytes_sent,
             threshold_settings);
    $display("  %0d good frames, %0d checksum errors, %0d mismatches", good_frames,
             csum_errors, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/fvrt_pkg.sv
rtl/fvrt_in_stage.sv
rtl/fvrt_parser.sv
rtl/framed_value_receiver_threshold.sv
bench/tb_framed_value_receiver_threshold.sv
